// ===== rtl/engine_rpm_from_pulse_times_core_macros.svh =====
// Assertion macros shared by the tachometer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ENGINE_RPM_FROM_PULSE_TIMES_CORE_MACROS_SVH
`define ENGINE_RPM_FROM_PULSE_TIMES_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ERPM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ERPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/erpm_pkg.sv =====
// Package for the tachometer: field widths, reset values, register indexes
// and the beat and status struct types. Depends on nothing.
package erpm_pkg;

	localparam int MAX_TRIGGERS_DEF = 16;

	localparam int TIME_W    = 32;
	localparam int RPM_W     = 27;
	localparam int TRIG_W    = 5;
	localparam int MIN_INT_W = 20;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [RPM_W-1:0] RPM_NUMERATOR = 27'd120000000;

	localparam logic [TRIG_W-1:0]    RESET_TRIGGER_COUNT = 5'd1;
	localparam logic [MIN_INT_W-1:0] RESET_MIN_INTERVAL  = 20'd3500;
	localparam logic [TIME_W-1:0]    RESET_TIMEOUT       = 32'd1000000;

	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 2'd2;

	localparam logic FUNC_EDGE = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef struct packed {
		logic              func;
		logic [TIME_W-1:0] time_us;
	} req_t;

	typedef struct packed {
		logic [RPM_W-1:0] rpm;
		logic             engine_off;
	} rsp_t;

	typedef struct packed {
		logic lt;
		logic nz;
	} ser_flags_t;

endpackage

// ===== rtl/engine_rpm_from_pulse_times_core.sv =====
// Period-based tachometer top level. Uses erpm_pkg, erpm_ram, erpm_ser, erpm_div
// and the assertion macros in engine_rpm_from_pulse_times_core_macros.svh.
//
// Each beat on req is either a tach edge or a speed read, stamped with a
// wrapping microsecond time. Edges closer than min_interval_us to the last
// accepted edge are dropped; accepted edges push the previous edge time into a
// ring of 2*trigger_count slots. A read returns 120000000 divided by the span
// over one four-stroke cycle, or rpm 0 with engine_off set when the oldest edge
// is at least timeout_us old or the span is zero. One item is in work at a
// time: req_ready stays low until it is done. The time differences run
// through 32-bit bit-serial subtractors, and a read that divides then runs
// through the one-bit-per-cycle divider. A finished result waits in the rsp
// register while the next beat is accepted. The ring starts out as all zero
// through per-slot valid bits, so no clearing pass is needed.
`include "engine_rpm_from_pulse_times_core_macros.svh"

module engine_rpm_from_pulse_times_core #(
	parameter int MAX_TRIGGERS = erpm_pkg::MAX_TRIGGERS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [erpm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [erpm_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  erpm_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output erpm_pkg::rsp_t                 rsp
);

	localparam int RingSlots = 2 * MAX_TRIGGERS;
	localparam int AddrW     = $clog2(RingSlots);
	localparam int SlotW     = AddrW + 1;
	localparam int TW        = erpm_pkg::TIME_W;
	localparam int CntW      = $clog2(TW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SHIFT,
		ST_EVAL,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                           state_q;
	logic [CntW-1:0]                  cnt_q;
	logic                             rsp_valid_q;
	erpm_pkg::rsp_t                   rsp_q;
	erpm_pkg::rsp_t                   res_q;
	erpm_pkg::req_t                   req_q;

	logic [erpm_pkg::TRIG_W-1:0]      trig_q;
	logic [erpm_pkg::MIN_INT_W-1:0]   min_int_q;
	logic [TW-1:0]                    timeout_q;

	logic [TW-1:0]                    last_q;
	logic [AddrW-1:0]                 pos_q;
	logic [RingSlots-1:0]             vld_q;
	logic                             vld_s1;

	logic [TW-1:0]                    now_sh_q;
	logic [TW-1:0]                    y_sh_q;
	logic [TW-1:0]                    x_sh_q;
	logic [TW-1:0]                    thr_sh_q;
	logic [TW-1:0]                    span_q;

	logic [TW-1:0]                    ram_rdata;
	logic [TW-1:0]                    oldest;
	logic                             ram_we;
	logic                             ser_clr;
	logic                             ser_en;
	logic                             d_age;
	logic                             d_span;
	erpm_pkg::ser_flags_t             age_flags;
	erpm_pkg::ser_flags_t             span_flags;
	logic                             engine_off;
	logic                             div_start;
	logic                             div_done;
	logic [erpm_pkg::RPM_W-1:0]       div_quo;

	logic [31:0]                      trig_ext;
	logic [31:0]                      trig_sat;
	logic [SlotW-1:0]                 slots;
	logic [SlotW-1:0]                 pos_inc;
	logic [AddrW-1:0]                 pos_next;

	// Effective ring length: a zero count acts as one, large counts saturate.
	always_comb begin
		trig_ext = 32'(trig_q);
		if (trig_ext == 32'd0) begin
			trig_sat = 32'd1;
		end else if (trig_ext > 32'(MAX_TRIGGERS)) begin
			trig_sat = 32'(MAX_TRIGGERS);
		end else begin
			trig_sat = trig_ext;
		end
		slots    = SlotW'({trig_sat[30:0], 1'b0});
		pos_inc  = SlotW'(pos_q) + 1'b1;
		pos_next = (pos_inc >= slots) ? '0 : pos_inc[AddrW-1:0];
	end

	assign oldest     = vld_s1 ? ram_rdata : '0;
	assign ser_clr    = (state_q == ST_LOAD);
	assign ser_en     = (state_q == ST_SHIFT);
	assign ram_we     = (state_q == ST_EVAL) && (req_q.func == erpm_pkg::FUNC_EDGE)
		&& !age_flags.lt;
	assign engine_off = !age_flags.lt || !span_flags.nz;
	assign div_start  = (state_q == ST_EVAL) && (req_q.func == erpm_pkg::FUNC_READ)
		&& !engine_off;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q    <= erpm_pkg::RESET_TRIGGER_COUNT;
			min_int_q <= erpm_pkg::RESET_MIN_INTERVAL;
			timeout_q <= erpm_pkg::RESET_TIMEOUT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				erpm_pkg::REG_TRIGGER_COUNT: begin
					trig_q <= cfg_wdata[erpm_pkg::TRIG_W-1:0];
				end
				erpm_pkg::REG_MIN_INTERVAL: begin
					min_int_q <= cfg_wdata[erpm_pkg::MIN_INT_W-1:0];
				end
				erpm_pkg::REG_TIMEOUT: begin
					timeout_q <= cfg_wdata[TW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			pos_q  <= '0;
			vld_q  <= '0;
		end else if (ram_we) begin
			last_q       <= req_q.time_us;
			pos_q        <= pos_next;
			vld_q[pos_q] <= 1'b1;
		end
	end

	erpm_ram #(
		.WIDTH(TW),
		.DEPTH(RingSlots)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (last_q),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		vld_s1 <= vld_q[pos_q];
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		case (state_q)
			ST_LOAD: begin
				now_sh_q <= req_q.time_us;
				y_sh_q   <= (req_q.func == erpm_pkg::FUNC_READ) ? oldest : last_q;
				x_sh_q   <= last_q;
				thr_sh_q <= (req_q.func == erpm_pkg::FUNC_READ) ? timeout_q
					: TW'(min_int_q);
			end
			ST_SHIFT: begin
				now_sh_q <= now_sh_q >> 1;
				y_sh_q   <= y_sh_q >> 1;
				x_sh_q   <= x_sh_q >> 1;
				thr_sh_q <= thr_sh_q >> 1;
				span_q   <= {d_span, span_q[TW-1:1]};
			end
			ST_EVAL: begin
				res_q.rpm        <= '0;
				res_q.engine_off <= 1'b1;
			end
			ST_DIV: begin
				if (div_done) begin
					res_q.rpm        <= div_quo;
					res_q.engine_off <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// Age of the oldest edge (or edge spacing) against its threshold.
	erpm_ser u_age (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (ser_clr),
		.en     (ser_en),
		.x      (now_sh_q[0]),
		.y      (y_sh_q[0]),
		.t      (thr_sh_q[0]),
		.d      (d_age),
		.flags  (age_flags)
	);

	// Span over one engine cycle, shifted into span_q.
	erpm_ser u_span (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (ser_clr),
		.en     (ser_en),
		.x      (x_sh_q[0]),
		.y      (y_sh_q[0]),
		.t      (1'b0),
		.d      (d_span),
		.flags  (span_flags)
	);

	erpm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.den    (span_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_ready && (state_q != ST_OUT)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(TW - 1)) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (req_q.func == erpm_pkg::FUNC_EDGE) begin
						state_q <= ST_IDLE;
					end else if (engine_off) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ERPM_ASSERT_IMPLY(a_off_means_zero, clk, arst_n, rsp_valid_q && rsp_q.engine_off, rsp_q.rpm == '0, "Engine off beat carries a nonzero rpm.")
	`ERPM_ASSERT_IMPLY(a_div_nonzero, clk, arst_n, div_start, span_q != '0, "Divider started with a zero span.")
	`ERPM_ASSERT_IMPLY(a_div_done_state, clk, arst_n, div_done, state_q == ST_DIV, "Divider finished outside the divide state.")
	`ERPM_ASSERT_IMPLY(a_pos_range, clk, arst_n, 1'b1, SlotW'(pos_q) < SlotW'(RingSlots), "Ring position beyond the ring.")
	`ERPM_ASSERT_NEXT(a_edge_stored, clk, arst_n, ram_we, last_q == $past(req_q.time_us) && req_ready, "Accepted edge time was not kept.")

endmodule

// ===== rtl/erpm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module erpm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/erpm_ser.sv =====
// Bit-serial subtractor and comparator: d = x - y one bit per cycle while en
// is high, LSB first; running compare of d with t, nonzero flag. Uses erpm_pkg.
module erpm_ser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   clr,
	input  logic                   en,
	input  logic                   x,
	input  logic                   y,
	input  logic                   t,
	output logic                   d,
	output erpm_pkg::ser_flags_t   flags
);

	logic br_q;
	logic cb_q;
	logic nz_q;
	logic br_n;
	logic cb_n;

	assign d    = x ^ y ^ br_q;
	assign br_n = (~x & y) | (~(x ^ y) & br_q);
	assign cb_n = (~d & t) | (~(d ^ t) & cb_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_q <= 1'b0;
			cb_q <= 1'b0;
			nz_q <= 1'b0;
		end else if (clr) begin
			br_q <= 1'b0;
			cb_q <= 1'b0;
			nz_q <= 1'b0;
		end else if (en) begin
			br_q <= br_n;
			cb_q <= cb_n;
			nz_q <= nz_q | d;
		end
	end

	// The final borrow of d - t means d < t.
	assign flags.lt = cb_q;
	assign flags.nz = nz_q;

endmodule

// ===== rtl/erpm_div.sv =====
// Radix-2 restoring divider that forms the RPM numerator divided by the span,
// one quotient bit per cycle. Uses erpm_pkg.
module erpm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [erpm_pkg::TIME_W-1:0] den,
	output logic                        done,
	output logic [erpm_pkg::RPM_W-1:0]  quo
);

	localparam int NW   = erpm_pkg::RPM_W;
	localparam int DW   = erpm_pkg::TIME_W;
	localparam int CNTW = $clog2(NW);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   rem_q;
	logic [NW-1:0]   num_q;
	logic [NW-1:0]   quo_q;
	logic [DW+1:0]   trial;
	logic            ge;

	assign trial = {1'b0, rem_q, num_q[NW-1]} - {2'b00, den};
	assign ge    = !trial[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNTW'(NW - 1)) begin
					busy_q <= 1'b0;
				end
				done_q <= (cnt_q == CNTW'(NW - 1));
				cnt_q  <= cnt_q + 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= erpm_pkg::RPM_NUMERATOR;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DW-1:0] : {rem_q[DW-2:0], num_q[NW-1]};
			num_q <= {num_q[NW-2:0], 1'b0};
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
